@@ rtl/cylcurl_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and codes for the cylindrical curl-of-H unit.
// No dependencies; imported by cylindrical_yee_curl_h_unit.
package cylcurl_pkg;

  // Port widths fixed by the item format
  localparam int CMD_W     = 3;
  localparam int RIDX_W    = 6;
  localparam int PIDX_W    = 5;
  localparam int ZIDX_W    = 6;
  localparam int CNT_W     = 6;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;

  // Default grid limits and fixed-point format
  localparam int DEF_MAX_NR    = 32;
  localparam int DEF_MAX_NPHI  = 32;
  localparam int DEF_MAX_NZ    = 32;
  localparam int DEF_FRAC_BITS = 16;

  // Register reset values
  localparam logic [CNT_W-1:0]  RST_COUNT = 6'd32;
  localparam logic [DATA_W-1:0] RST_STEP  = 32'd65536;

  // Intermediate saturation bound +-(2^62-1)
  localparam logic [63:0]        WIDE_SAT   = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] WIDE_SAT65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_R     = 3'd0,
    CMD_WR_PHI   = 3'd1,
    CMD_WR_Z     = 3'd2,
    CMD_CURL_R   = 3'd3,
    CMD_CURL_PHI = 3'd4,
    CMD_CURL_Z   = 3'd5
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_R    = 3'd0,
    REG_NUM_PHI  = 3'd1,
    REG_NUM_Z    = 3'd2,
    REG_DR       = 3'd3,
    REG_INV_DR   = 3'd4,
    REG_INV_DPHI = 3'd5,
    REG_INV_DZ   = 3'd6
  } cfg_reg_t;

endpackage

@@ rtl/cylindrical_yee_curl_h_unit.sv @@
`timescale 1ns / 1ps
// Curl of H on a cylindrical staggered grid: field memories, sequencer, shared mul/div.
// Depends on cylcurl_pkg.
//
// Write items (Hr, Hphi, Hz) are stored as they are accepted and give no result. A
// compute item reads four stored words, then a small micro-program runs on one shared
// 32x32 multiplier, which builds each 64x64 product from 32x32 partial products, and
// one radix-2 divider, which is skipped when the dividend is zero. An index out of
// range skips the reads and the arithmetic. cmd_ready is low while an item is in
// work. The result sits in an output register, so the next item is taken while it
// waits. Entries must be written before they are read.
module cylindrical_yee_curl_h_unit #(
  parameter int MAX_NR    = cylcurl_pkg::DEF_MAX_NR,
  parameter int MAX_NPHI  = cylcurl_pkg::DEF_MAX_NPHI,
  parameter int MAX_NZ    = cylcurl_pkg::DEF_MAX_NZ,
  parameter int FRAC_BITS = cylcurl_pkg::DEF_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [cylcurl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cylcurl_pkg::DATA_W-1:0]        cfg_data,
  input  logic                                  cmd_valid,
  output logic                                  cmd_ready,
  input  logic [cylcurl_pkg::CMD_W-1:0]         cmd,
  input  logic [cylcurl_pkg::RIDX_W-1:0]        r_index,
  input  logic [cylcurl_pkg::PIDX_W-1:0]        phi_index,
  input  logic [cylcurl_pkg::ZIDX_W-1:0]        z_index,
  input  logic signed [cylcurl_pkg::DATA_W-1:0] field_value,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic signed [cylcurl_pkg::DATA_W-1:0] curl_value,
  output logic                                  index_error
);
  import cylcurl_pkg::*;

  localparam int HR_DEPTH = (MAX_NR + 1) * MAX_NPHI * MAX_NZ;
  localparam int HP_DEPTH = MAX_NR * MAX_NPHI * MAX_NZ;
  localparam int HZ_DEPTH = MAX_NR * MAX_NPHI * (MAX_NZ + 1);
  localparam int HR_AW    = $clog2(HR_DEPTH);
  localparam int HP_AW    = $clog2(HP_DEPTH);
  localparam int HZ_AW    = $clog2(HZ_DEPTH);
  localparam int DIV_BITS = 64 + FRAC_BITS;
  localparam int DC_W     = $clog2(DIV_BITS + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_DISP, ST_MUL, ST_DIV, ST_FIN} state_t;
  typedef enum logic [1:0] {MEM_HR, MEM_HP, MEM_HZ} mem_t;
  typedef enum logic [2:0] {OP_SUB, OP_ADD, OP_MUL, OP_DIV, OP_DONE} op_t;
  typedef enum logic [1:0] {SH_FRAC, SH_ONE, SH_NONE} sh_t;
  typedef enum logic [3:0] {
    S_V0, S_V1, S_V2, S_V3, S_T4, S_T5, S_T6, S_T7,
    S_INVR, S_INVP, S_INVZ, S_DR, S_I, S_I2P1, S_I2M1
  } src_t;
  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    sh_t  sh;
    src_t dst;
  } uop_t;

  // Configuration registers
  logic [CNT_W-1:0]  num_r, num_phi, num_z;
  logic [DATA_W-1:0] radial_step, inv_radial_step, inv_phi_step, inv_z_step;

  // Control and operand registers
  state_t            state;
  cmd_t              op_cmd;
  logic [CNT_W-1:0]  op_i, op_j, op_jm1, op_k;
  logic [2:0]        rcnt;
  logic [1:0]        rd_slot;
  mem_t              rd_memq;
  logic              rd_gq, rd_pend;
  logic [3:0]        step;
  logic signed [63:0] v0, v1, v2, v3, t4, t5, t6, t7;
  logic signed [DATA_W-1:0] res_q;
  logic              err_q;

  // Multiplier state
  logic [63:0]       mul_mag, mul_b;
  logic              mul_neg;
  sh_t               mul_sh;
  logic [2:0]        mcnt;
  logic [127:0]      mul_acc;
  src_t              op_dst;

  // Divider state
  logic [DIV_BITS-1:0] div_num;
  logic [63:0]       div_d, div_rem, div_quo;
  logic              div_neg, div_sat;
  logic [DC_W-1:0]   dcnt;

  // Memories
  logic signed [DATA_W-1:0] hr_mem [HR_DEPTH];
  logic signed [DATA_W-1:0] hp_mem [HP_DEPTH];
  logic signed [DATA_W-1:0] hz_mem [HZ_DEPTH];
  logic signed [DATA_W-1:0] hr_rdata, hp_rdata, hz_rdata;
  logic [HR_AW-1:0]  hr_waddr, hr_raddr;
  logic [HP_AW-1:0]  hp_waddr, hp_raddr;
  logic [HZ_AW-1:0]  hz_waddr, hz_raddr;
  logic              hr_we, hp_we, hz_we;

  // Combinational helpers
  logic              accept;
  cmd_t              in_cmd;
  logic [CNT_W-1:0]  nr, np, nz, in_j, in_jm1;
  logic              in_ok;
  mem_t              rd_mem;
  logic [CNT_W-1:0]  rd_i, rd_j, rd_k;
  logic              rd_g;
  uop_t              uop;
  logic [6:0]        i2m1;
  logic signed [63:0] a_val, b_val, alu_res, mul_res, div_res, done_val;
  logic [63:0]       a_mag;
  logic signed [64:0] alu_sum;
  logic [31:0]       a_half, b_half;
  logic [63:0]       pp;
  logic [127:0]      pp_sh, mul_shifted;
  logic [63:0]       mul_clip, div_clip;
  logic [64:0]       rem_sh, rem_nx;
  logic              qb;
  logic [63:0]       quo_nx;
  logic              wb_en;
  src_t              wb_dst;
  logic signed [63:0] wb_val;
  logic signed [DATA_W-1:0] rdata_sel;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v, input int maxv);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (int'(v) > maxv) r = CNT_W'(maxv);
    else r = v;
    return r;
  endfunction

  function automatic logic [HR_AW-1:0] hr_addr(input logic [CNT_W-1:0] i, j, k);
    return HR_AW'(i) + HR_AW'(MAX_NR + 1) * (HR_AW'(j) + HR_AW'(MAX_NPHI) * HR_AW'(k));
  endfunction

  function automatic logic [HP_AW-1:0] hp_addr(input logic [CNT_W-1:0] i, j, k);
    return HP_AW'(i) + HP_AW'(MAX_NR) * (HP_AW'(j) + HP_AW'(MAX_NPHI) * HP_AW'(k));
  endfunction

  function automatic logic [HZ_AW-1:0] hz_addr(input logic [CNT_W-1:0] i, j, k);
    return HZ_AW'(i) + HZ_AW'(MAX_NR) * (HZ_AW'(j) + HZ_AW'(MAX_NPHI) * HZ_AW'(k));
  endfunction

  function automatic uop_t mk(input op_t op, input src_t a, input src_t b,
                              input sh_t sh, input src_t dst);
    uop_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.sh  = sh;
    u.dst = dst;
    return u;
  endfunction

  function automatic logic signed [63:0] sext32(input logic signed [DATA_W-1:0] x);
    return {{(64 - DATA_W){x[DATA_W-1]}}, x};
  endfunction

  // Effective counts and input checks
  assign accept = cmd_valid && cmd_ready;
  assign in_cmd = cmd_t'(cmd);
  assign nr     = eff_count(num_r, MAX_NR);
  assign np     = eff_count(num_phi, MAX_NPHI);
  assign nz     = eff_count(num_z, MAX_NZ);
  assign in_j   = CNT_W'(phi_index);
  assign in_jm1 = (in_j == '0) ? np - CNT_W'(1) : in_j - CNT_W'(1);

  always_comb begin
    case (in_cmd)
      CMD_CURL_R:   in_ok = (r_index < nr) && (in_j < np) && (z_index <= nz);
      CMD_CURL_PHI: in_ok = (r_index <= nr) && (in_j < np) && (z_index <= nz);
      CMD_CURL_Z:   in_ok = (r_index <= nr) && (in_j < np) && (z_index < nz);
      default:      in_ok = 1'b0;
    endcase
  end

  // Memory writes straight from the accepted item
  assign hr_we = accept && (in_cmd == CMD_WR_R) && (r_index <= nr) && (in_j < np)
                 && (z_index < nz);
  assign hp_we = accept && (in_cmd == CMD_WR_PHI) && (r_index < nr) && (in_j < np)
                 && (z_index < nz);
  assign hz_we = accept && (in_cmd == CMD_WR_Z) && (r_index < nr) && (in_j < np)
                 && (z_index <= nz);
  assign hr_waddr = hr_addr(r_index, in_j, z_index);
  assign hp_waddr = hp_addr(r_index, in_j, z_index);
  assign hz_waddr = hz_addr(r_index, in_j, z_index);

  // Read schedule: four neighbor words per compute, guard false reads as zero
  always_comb begin
    rd_mem = MEM_HZ;
    rd_i   = op_i;
    rd_j   = op_j;
    rd_k   = op_k;
    rd_g   = 1'b1;
    case (op_cmd)
      CMD_CURL_R: begin
        case (rcnt[1:0])
          2'd0: rd_mem = MEM_HZ;
          2'd1: begin rd_mem = MEM_HZ; rd_j = op_jm1; end
          2'd2: begin rd_mem = MEM_HP; rd_g = (op_k < nz); end
          default: begin
            rd_mem = MEM_HP; rd_k = op_k - CNT_W'(1); rd_g = (op_k != '0);
          end
        endcase
      end
      CMD_CURL_PHI: begin
        case (rcnt[1:0])
          2'd0: begin rd_mem = MEM_HR; rd_g = (op_k < nz); end
          2'd1: begin
            rd_mem = MEM_HR; rd_k = op_k - CNT_W'(1); rd_g = (op_k != '0);
          end
          2'd2: begin rd_mem = MEM_HZ; rd_g = (op_i < nr); end
          default: begin
            rd_mem = MEM_HZ; rd_i = op_i - CNT_W'(1); rd_g = (op_i != '0);
          end
        endcase
      end
      default: begin
        case (rcnt[1:0])
          2'd0: begin rd_mem = MEM_HP; rd_g = (op_i < nr); end
          2'd1: begin
            rd_mem = MEM_HP; rd_i = op_i - CNT_W'(1); rd_g = (op_i != '0);
          end
          2'd2: rd_mem = MEM_HR;
          default: begin rd_mem = MEM_HR; rd_j = op_jm1; end
        endcase
      end
    endcase
  end

  assign hr_raddr = hr_addr(rd_i, rd_j, rd_k);
  assign hp_raddr = hp_addr(rd_i, rd_j, rd_k);
  assign hz_raddr = hz_addr(rd_i, rd_j, rd_k);

  // Field memories, registered read
  always_ff @(posedge clk) begin
    if (hr_we) hr_mem[hr_waddr] <= field_value;
    hr_rdata <= hr_mem[hr_raddr];
  end

  always_ff @(posedge clk) begin
    if (hp_we) hp_mem[hp_waddr] <= field_value;
    hp_rdata <= hp_mem[hp_raddr];
  end

  always_ff @(posedge clk) begin
    if (hz_we) hz_mem[hz_waddr] <= field_value;
    hz_rdata <= hz_mem[hz_raddr];
  end

  always_comb begin
    case (rd_memq)
      MEM_HR:  rdata_sel = hr_rdata;
      MEM_HP:  rdata_sel = hp_rdata;
      default: rdata_sel = hz_rdata;
    endcase
  end

  // Micro-program, one entry per step
  always_comb begin
    uop = mk(OP_DONE, S_T4, S_T4, SH_NONE, S_T4);
    case (op_cmd)
      CMD_CURL_R: begin
        case (step)
          4'd0: uop = mk(OP_SUB, S_V0,   S_V1, SH_NONE, S_T4);
          4'd1: uop = mk(OP_MUL, S_T4,   S_INVP, SH_FRAC, S_T4);
          4'd2: uop = mk(OP_SUB, S_V2,   S_V3, SH_NONE, S_T5);
          4'd3: uop = mk(OP_MUL, S_T5,   S_INVZ, SH_FRAC, S_T5);
          4'd4: uop = mk(OP_MUL, S_I2P1, S_DR, SH_ONE, S_T6);
          4'd5: uop = mk(OP_DIV, S_T4,   S_T6, SH_NONE, S_T4);
          4'd6: uop = mk(OP_SUB, S_T4,   S_T5, SH_NONE, S_T4);
          default: uop = mk(OP_DONE, S_T4, S_T4, SH_NONE, S_T4);
        endcase
      end
      CMD_CURL_PHI: begin
        case (step)
          4'd0: uop = mk(OP_SUB, S_V0, S_V1, SH_NONE, S_T4);
          4'd1: uop = mk(OP_MUL, S_T4, S_INVZ, SH_FRAC, S_T4);
          4'd2: uop = mk(OP_SUB, S_V2, S_V3, SH_NONE, S_T5);
          4'd3: uop = mk(OP_MUL, S_T5, S_INVR, SH_FRAC, S_T5);
          4'd4: uop = mk(OP_SUB, S_T4, S_T5, SH_NONE, S_T4);
          default: uop = mk(OP_DONE, S_T4, S_T4, SH_NONE, S_T4);
        endcase
      end
      default: begin
        case (step)
          4'd0:  uop = mk(OP_MUL, S_I2P1, S_DR, SH_ONE, S_T6);
          4'd1:  uop = mk(OP_MUL, S_V0,   S_T6, SH_FRAC, S_T4);
          4'd2:  uop = mk(OP_MUL, S_I2M1, S_DR, SH_ONE, S_T6);
          4'd3:  uop = mk(OP_MUL, S_V1,   S_T6, SH_FRAC, S_T5);
          4'd4:  uop = mk(OP_SUB, S_T4,   S_T5, SH_NONE, S_T4);
          4'd5:  uop = mk(OP_MUL, S_T4,   S_INVR, SH_FRAC, S_T4);
          4'd6:  uop = mk(OP_SUB, S_V2,   S_V3, SH_NONE, S_T5);
          4'd7:  uop = mk(OP_MUL, S_T5,   S_INVP, SH_FRAC, S_T5);
          4'd8:  uop = mk(OP_MUL, S_I,    S_DR, SH_NONE, S_T6);
          4'd9:  uop = mk(OP_SUB, S_T4,   S_T5, SH_NONE, S_T7);
          4'd10: uop = mk(OP_ADD, S_T4,   S_T4, SH_NONE, S_T5);
          4'd11: uop = mk(OP_DIV, S_T7,   S_T6, SH_NONE, S_T4);
          default: uop = mk(OP_DONE, S_T4, S_T4, SH_NONE, S_T4);
        endcase
      end
    endcase
  end

  // Operand selection
  assign i2m1 = {op_i, 1'b1} - 7'd2;

  function automatic logic signed [63:0] pick(input src_t s);
    logic signed [63:0] r;
    case (s)
      S_V0:   r = v0;
      S_V1:   r = v1;
      S_V2:   r = v2;
      S_V3:   r = v3;
      S_T4:   r = t4;
      S_T5:   r = t5;
      S_T6:   r = t6;
      S_T7:   r = t7;
      S_INVR: r = $signed(64'(inv_radial_step));
      S_INVP: r = $signed(64'(inv_phi_step));
      S_INVZ: r = $signed(64'(inv_z_step));
      S_DR:   r = $signed(64'(radial_step));
      S_I:    r = $signed(64'(op_i));
      S_I2P1: r = $signed(64'({op_i, 1'b1}));
      S_I2M1: r = $signed(64'(i2m1));
      default: r = '0;
    endcase
    return r;
  endfunction

  assign a_val = pick(uop.a);
  assign b_val = pick(uop.b);
  assign a_mag = a_val[63] ? 64'(-a_val) : 64'(a_val);

  // Saturating add/subtract
  always_comb begin
    if (uop.op == OP_ADD) alu_sum = {a_val[63], a_val} + {b_val[63], b_val};
    else alu_sum = {a_val[63], a_val} - {b_val[63], b_val};
    if (alu_sum > WIDE_SAT65) alu_res = $signed(WIDE_SAT);
    else if (alu_sum < -WIDE_SAT65) alu_res = -$signed(WIDE_SAT);
    else alu_res = alu_sum[63:0];
  end

  // Shared multiplier: one 32x32 partial product per cycle
  assign a_half = mcnt[0] ? mul_mag[63:32] : mul_mag[31:0];
  assign b_half = mcnt[1] ? mul_b[63:32] : mul_b[31:0];
  assign pp     = 64'(a_half) * 64'(b_half);

  always_comb begin
    case ({1'b0, mcnt[0]} + {1'b0, mcnt[1]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    case (mul_sh)
      SH_FRAC: mul_shifted = mul_acc >> FRAC_BITS;
      SH_ONE:  mul_shifted = mul_acc >> 1;
      default: mul_shifted = mul_acc;
    endcase
    mul_clip = (mul_shifted > {64'd0, WIDE_SAT}) ? WIDE_SAT : mul_shifted[63:0];
    mul_res  = mul_neg ? -$signed(mul_clip) : $signed(mul_clip);
  end

  // Shared divider: restoring, one quotient bit per cycle
  always_comb begin
    rem_sh  = {div_rem, div_num[DIV_BITS-1]};
    qb      = (rem_sh >= {1'b0, div_d});
    rem_nx  = qb ? rem_sh - {1'b0, div_d} : rem_sh;
    quo_nx  = {div_quo[62:0], qb};
    div_clip = div_sat ? WIDE_SAT : div_quo;
    div_res  = div_neg ? -$signed(div_clip) : $signed(div_clip);
  end

  // curl z at zero radius takes twice the radial term
  assign done_val = ((op_cmd == CMD_CURL_Z) && (t6 == '0)) ? t5 : t4;

  // Register write-back; a zero dividend gives a zero quotient at dispatch
  always_comb begin
    wb_en  = 1'b0;
    wb_dst = S_T4;
    wb_val = alu_res;
    case (state)
      ST_READ: begin
        wb_en  = rd_pend;
        wb_dst = src_t'({2'b00, rd_slot});
        wb_val = rd_gq ? sext32(rdata_sel) : '0;
      end
      ST_DISP: begin
        wb_en  = (uop.op == OP_SUB) || (uop.op == OP_ADD)
                 || ((uop.op == OP_DIV) && (a_val == '0));
        wb_dst = uop.dst;
        wb_val = (uop.op == OP_DIV) ? '0 : alu_res;
      end
      ST_MUL: begin
        wb_en  = (mcnt == 3'd4);
        wb_dst = op_dst;
        wb_val = mul_res;
      end
      ST_DIV: begin
        wb_en  = (dcnt == DC_W'(DIV_BITS));
        wb_dst = op_dst;
        wb_val = div_res;
      end
      default: wb_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      case (wb_dst)
        S_V0:    v0 <= wb_val;
        S_V1:    v1 <= wb_val;
        S_V2:    v2 <= wb_val;
        S_V3:    v3 <= wb_val;
        S_T4:    t4 <= wb_val;
        S_T5:    t5 <= wb_val;
        S_T6:    t6 <= wb_val;
        default: t7 <= wb_val;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_r           <= RST_COUNT;
      num_phi         <= RST_COUNT;
      num_z           <= RST_COUNT;
      radial_step     <= RST_STEP;
      inv_radial_step <= RST_STEP;
      inv_phi_step    <= RST_STEP;
      inv_z_step      <= RST_STEP;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUM_R:    num_r           <= cfg_data[CNT_W-1:0];
        REG_NUM_PHI:  num_phi         <= cfg_data[CNT_W-1:0];
        REG_NUM_Z:    num_z           <= cfg_data[CNT_W-1:0];
        REG_DR:       radial_step     <= cfg_data;
        REG_INV_DR:   inv_radial_step <= cfg_data;
        REG_INV_DPHI: inv_phi_step    <= cfg_data;
        REG_INV_DZ:   inv_z_step      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cmd_ready = (state == ST_IDLE);

  // Sequencer, arithmetic unit control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != ST_FIN)) result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          rd_pend <= 1'b0;
          if (accept) begin
            op_i   <= r_index;
            op_j   <= in_j;
            op_jm1 <= in_jm1;
            op_k   <= z_index;
            case (in_cmd)
              CMD_CURL_R, CMD_CURL_PHI, CMD_CURL_Z: begin
                op_cmd <= in_cmd;
                rcnt   <= '0;
                if (in_ok) begin
                  state <= ST_READ;
                end else begin
                  res_q <= '0;
                  err_q <= 1'b1;
                  state <= ST_FIN;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_READ: begin
          rd_slot <= rcnt[1:0];
          rd_memq <= rd_mem;
          rd_gq   <= rd_g;
          rd_pend <= (rcnt < 3'd4);
          rcnt    <= rcnt + 3'd1;
          if (rcnt == 3'd4) begin
            step  <= '0;
            state <= ST_DISP;
          end
        end
        ST_DISP: begin
          case (uop.op)
            OP_SUB, OP_ADD: step <= step + 4'd1;
            OP_MUL: begin
              mul_mag <= a_mag;
              mul_neg <= a_val[63];
              mul_b   <= 64'(b_val);
              mul_sh  <= uop.sh;
              mul_acc <= '0;
              mcnt    <= '0;
              op_dst  <= uop.dst;
              state   <= ST_MUL;
            end
            OP_DIV: begin
              if (a_val == '0) begin
                step <= step + 4'd1;
              end else begin
                div_num <= {a_mag, {FRAC_BITS{1'b0}}};
                div_neg <= a_val[63];
                div_d   <= 64'(b_val);
                div_rem <= '0;
                div_quo <= '0;
                div_sat <= 1'b0;
                dcnt    <= '0;
                op_dst  <= uop.dst;
                state   <= ST_DIV;
              end
            end
            default: begin
              if (done_val > 64'sh0000_0000_7FFF_FFFF) res_q <= 32'sh7FFF_FFFF;
              else if (done_val < -64'sh0000_0000_8000_0000) res_q <= 32'sh8000_0000;
              else res_q <= done_val[DATA_W-1:0];
              err_q <= 1'b0;
              state <= ST_FIN;
            end
          endcase
        end
        ST_MUL: begin
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd4) begin
            step  <= step + 4'd1;
            state <= ST_DISP;
          end else begin
            mul_acc <= mul_acc + pp_sh;
          end
        end
        ST_DIV: begin
          dcnt <= dcnt + DC_W'(1);
          if (dcnt == DC_W'(DIV_BITS)) begin
            step  <= step + 4'd1;
            state <= ST_DISP;
          end else begin
            div_num <= div_num << 1;
            div_rem <= rem_nx[63:0];
            if (!div_sat) begin
              div_quo <= quo_nx;
              if (quo_nx > WIDE_SAT) div_sat <= 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            curl_value   <= res_q;
            index_error  <= err_q;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && index_error |-> curl_value == '0)
    else $error("index error result carries a nonzero value");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (in_cmd == CMD_CURL_R || in_cmd == CMD_CURL_PHI || in_cmd == CMD_CURL_Z)
    |=> !cmd_ready)
    else $error("compute item did not hold off the next item");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && div_d != '0 |-> div_rem < div_d)
    else $error("divider remainder not below divisor");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && dcnt != DC_W'(DIV_BITS) && div_sat |=> div_sat)
    else $error("divider saturation flag dropped mid-quotient");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DISP |-> step <= 4'd12)
    else $error("micro-program step out of range");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for cylindrical_yee_curl_h_unit: random and directed field writes
// and curl computes checked against a behavioral curl predictor. Depends on cylcurl_pkg.
module testbench;
  import cylcurl_pkg::*;

  localparam longint SAT62 = longint'(WIDE_SAT);
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [31:0] value;
    logic        err;
  } curl_result_t;

  typedef struct {
    cmd_t       wc;
    logic [5:0] i;
    logic [4:0] j;
    logic [5:0] k;
  } field_point_t;

  // Curl predictor: mirror of the field stores and registers, plus the queue of
  // curl results still owed by the block.
  class curl_scoreboard;
    bit [5:0]     num_r_q, num_phi_q, num_z_q;
    bit [63:0]    dr_q, inv_dr_q, inv_dphi_q, inv_dz_q;
    int           field_mem[longint];
    field_point_t missing[$];
    curl_result_t owed[$];
    int           failures;

    function new();
      num_r_q = 32; num_phi_q = 32; num_z_q = 32;
      dr_q = 65536; inv_dr_q = 65536; inv_dphi_q = 65536; inv_dz_q = 65536;
      failures = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [31:0] v);
      case (idx)
        REG_NUM_R:    num_r_q = v[5:0];
        REG_NUM_PHI:  num_phi_q = v[5:0];
        REG_NUM_Z:    num_z_q = v[5:0];
        REG_DR:       dr_q = {32'd0, v};
        REG_INV_DR:   inv_dr_q = {32'd0, v};
        REG_INV_DPHI: inv_dphi_q = {32'd0, v};
        REG_INV_DZ:   inv_dz_q = {32'd0, v};
        default: ;
      endcase
    endfunction

    function int eff(bit [5:0] v);
      if (v == 0) return 1;
      return (v > 32) ? 32 : int'(v);
    endfunction

    function longint addr(cmd_t wc, int i, int j, int k);
      if (wc == CMD_WR_R) return longint'(wc) * 65536 + i + 33 * (j + 32 * k);
      return longint'(wc) * 65536 + i + 32 * (j + 32 * k);
    endfunction

    // Unwritten reads are logged so the stimulus can fill them first
    function longint rd(cmd_t wc, int i, int j, int k);
      field_point_t p;
      longint a;
      a = addr(wc, i, j, k);
      if (field_mem.exists(a)) return longint'(field_mem[a]);
      p.wc = wc; p.i = 6'(i); p.j = 5'(j); p.k = 6'(k);
      missing.push_back(p);
      return 0;
    endfunction

    function longint sat(longint v);
      if (v > SAT62) return SAT62;
      if (v < -SAT62) return -SAT62;
      return v;
    endfunction

    // trunc(a*b/2^16), saturated
    function longint mulq(longint a, bit [63:0] b);
      bit [127:0] p;
      bit [63:0]  m;
      longint     v;
      m = (a < 0) ? 64'(-a) : 64'(a);
      p = (128'(m) * 128'(b)) >> DEF_FRAC_BITS;
      v = (p > 128'(SAT62)) ? SAT62 : longint'(p[63:0]);
      return (a < 0) ? -v : v;
    endfunction

    // trunc(a*2^16/d), saturated; zero divisor gives full scale
    function longint divq(longint a, bit [63:0] d);
      bit [127:0] q;
      bit [63:0]  m;
      longint     v;
      if (a == 0) return 0;
      if (d == 0) return (a < 0) ? -SAT62 : SAT62;
      m = (a < 0) ? 64'(-a) : 64'(a);
      q = (128'(m) << DEF_FRAC_BITS) / 128'(d);
      v = (q > 128'(SAT62)) ? SAT62 : longint'(q[63:0]);
      return (a < 0) ? -v : v;
    endfunction

    function bit [63:0] rhalf(int i);
      return (64'(2 * i + 1) * dr_q) >> 1;
    endfunction

    function void curl(logic [2:0] c, int i, int j, int k, output curl_result_t r);
      int nr, np, nz, jm1;
      bit ok;
      longint res, up, dn, a, b, drp, dpr;
      bit [63:0] ri;
      nr = eff(num_r_q); np = eff(num_phi_q); nz = eff(num_z_q);
      res = 0;
      if (c == CMD_CURL_R) ok = i < nr && j < np && k <= nz;
      else if (c == CMD_CURL_PHI) ok = i <= nr && j < np && k <= nz;
      else ok = i <= nr && j < np && k < nz;
      if (ok) begin
        jm1 = (j == 0) ? np - 1 : j - 1;
        case (c)
          CMD_CURL_R: begin
            a = mulq(rd(CMD_WR_Z, i, j, k) - rd(CMD_WR_Z, i, jm1, k), inv_dphi_q);
            up = (k < nz) ? rd(CMD_WR_PHI, i, j, k) : 0;
            dn = (k > 0) ? rd(CMD_WR_PHI, i, j, k - 1) : 0;
            b = mulq(up - dn, inv_dz_q);
            res = sat(divq(a, rhalf(i)) - b);
          end
          CMD_CURL_PHI: begin
            up = (k < nz) ? rd(CMD_WR_R, i, j, k) : 0;
            dn = (k > 0) ? rd(CMD_WR_R, i, j, k - 1) : 0;
            a = (i < nr) ? rd(CMD_WR_Z, i, j, k) : 0;
            b = (i > 0) ? rd(CMD_WR_Z, i - 1, j, k) : 0;
            res = sat(mulq(up - dn, inv_dz_q) - mulq(a - b, inv_dr_q));
          end
          default: begin
            a = (i < nr) ? mulq(rd(CMD_WR_PHI, i, j, k), rhalf(i)) : 0;
            b = (i > 0) ? mulq(rd(CMD_WR_PHI, i - 1, j, k), rhalf(i - 1)) : 0;
            drp = mulq(sat(a - b), inv_dr_q);
            dpr = mulq(rd(CMD_WR_R, i, j, k) - rd(CMD_WR_R, i, jm1, k), inv_dphi_q);
            ri = 64'(i) * dr_q;
            // on the axis the z curl is twice the radial derivative
            if (ri == 0) res = sat(drp * 2);
            else res = divq(sat(drp - dpr), ri);
          end
        endcase
        if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
        if (res < -64'sh8000_0000) res = -64'sh8000_0000;
      end
      r.value = res[31:0];
      r.err = !ok;
    endfunction

    // Collect the unwritten entries that a compute would read
    function void probe(logic [2:0] c, int i, int j, int k);
      curl_result_t r;
      missing.delete();
      if (c >= CMD_CURL_R && c <= CMD_CURL_Z) curl(c, i, j, k, r);
    endfunction

    function void note_item(logic [2:0] c, int i, int j, int k, logic [31:0] fv);
      int nr, np, nz;
      curl_result_t r;
      nr = eff(num_r_q); np = eff(num_phi_q); nz = eff(num_z_q);
      case (c)
        CMD_WR_R:   if (i <= nr && j < np && k < nz) field_mem[addr(CMD_WR_R, i, j, k)] = fv;
        CMD_WR_PHI: if (i < nr && j < np && k < nz) field_mem[addr(CMD_WR_PHI, i, j, k)] = fv;
        CMD_WR_Z:   if (i < nr && j < np && k <= nz) field_mem[addr(CMD_WR_Z, i, j, k)] = fv;
        CMD_CURL_R, CMD_CURL_PHI, CMD_CURL_Z: begin
          curl(c, i, j, k, r);
          owed.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] v, logic e);
      curl_result_t x;
      if (owed.size() == 0) begin
        if (failures < 10) $display("unexpected result: curl %h err %b", v, e);
        failures++;
        return;
      end
      x = owed.pop_front();
      if (x.value !== v || x.err !== e) begin
        if (failures < 10)
          $display("curl mismatch: expected %h err %b, got %h err %b", x.value, x.err, v, e);
        failures++;
      end
    endfunction
  endclass

  logic                      clk, rst;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [DATA_W-1:0]         cfg_data;
  logic                      cmd_valid, cmd_ready;
  logic [CMD_W-1:0]          cmd;
  logic [RIDX_W-1:0]         r_index;
  logic [PIDX_W-1:0]         phi_index;
  logic [ZIDX_W-1:0]         z_index;
  logic signed [DATA_W-1:0]  field_value;
  logic                      result_valid, result_ready;
  logic signed [DATA_W-1:0]  curl_value;
  logic                      index_error;

  curl_scoreboard sb = new();
  bit tx_idle, rx_idle, hold_request;
  int idle_cycles;

  cylindrical_yee_curl_h_unit DUT (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog: too long with no handshake and no register write
  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (result_valid && result_ready) || cfg_write)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Result side: random stalls per item, plus a long hold-off on request
  initial begin
    int stall, hold;
    stall = 0; hold = 0;
    result_ready <= 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (result_valid && result_ready) begin
          sb.check_result(curl_value, index_error);
          stall = rx_idle ? $urandom_range(0, 7) : 0;
        end
        if (hold_request) begin
          hold = HOLD_CYCLES;
          hold_request = 0;
        end
        if (hold > 0) begin
          hold--;
          result_ready <= 0;
        end else if (stall > 0) begin
          stall--;
          result_ready <= 0;
        end else begin
          result_ready <= 1;
        end
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  // One input item; valid stays up across back-to-back items
  task automatic send_item(logic [2:0] c, logic [5:0] i, logic [4:0] j, logic [5:0] k,
                           logic [31:0] v);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      cmd_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c; r_index <= i; phi_index <= j; z_index <= k; field_value <= v;
    cmd_valid <= 1;
    do @(posedge clk); while (!cmd_ready);
    sb.note_item(c, i, j, k, v);
  endtask

  // Compute item preceded by writes of any entries it reads that were never written
  task automatic run_compute(logic [2:0] c, logic [5:0] i, logic [4:0] j, logic [5:0] k);
    field_point_t fill[$];
    sb.probe(c, i, j, k);
    fill = sb.missing;
    foreach (fill[n]) send_item(fill[n].wc, fill[n].i, fill[n].j, fill[n].k, rand_value());
    send_item(c, i, j, k, $urandom);
  endtask

  task automatic settle();
    cmd_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [5:0] nr, logic [5:0] np, logic [5:0] nz, logic [31:0] dr,
                           logic [31:0] idr, logic [31:0] idp, logic [31:0] idz);
    settle();
    write_reg(REG_NUM_R, 32'(nr));
    write_reg(REG_NUM_PHI, 32'(np));
    write_reg(REG_NUM_Z, 32'(nz));
    write_reg(REG_DR, dr);
    write_reg(REG_INV_DR, idr);
    write_reg(REG_INV_DPHI, idp);
    write_reg(REG_INV_DZ, idz);
    tx_idle = $urandom_range(0, 3) != 0;
    rx_idle = $urandom_range(0, 3) != 0;
  endtask

  // Mostly in-range computes on written data; the rest is overwrites, stray items and noise
  task automatic random_phase(int computes);
    int nr, np, nz, sel, done;
    logic [2:0] c;
    nr = sb.eff(sb.num_r_q); np = sb.eff(sb.num_phi_q); nz = sb.eff(sb.num_z_q);
    done = 0;
    while (done < computes) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        c = 3'($urandom_range(CMD_CURL_R, CMD_CURL_Z));
        run_compute(c,
                    6'((c == CMD_CURL_R) ? $urandom_range(0, nr - 1) : $urandom_range(0, nr)),
                    5'($urandom_range(0, np - 1)),
                    6'((c == CMD_CURL_Z) ? $urandom_range(0, nz - 1) : $urandom_range(0, nz)));
        done++;
      end else if (sel < 80) begin
        // overwrite in-range entries so stored data keeps changing
        send_item(3'($urandom_range(CMD_WR_R, CMD_WR_Z)), 6'($urandom_range(0, nr - 1)),
                  5'($urandom_range(0, np - 1)), 6'($urandom_range(0, nz - 1)),
                  rand_value());
      end else if (sel < 88) begin
        send_item(3'($urandom_range(CMD_WR_R, CMD_WR_Z)), 6'($urandom), 5'($urandom),
                  6'($urandom), rand_value());
      end else if (sel < 96) begin
        run_compute(3'($urandom_range(CMD_CURL_R, CMD_CURL_Z)), 6'($urandom), 5'($urandom),
                    6'($urandom));
        done++;
      end else begin
        send_item(3'($urandom_range(6, 7)), 6'($urandom), 5'($urandom), 6'($urandom),
                  $urandom);
      end
    end
  endtask

  initial begin
    rst <= 1;
    cfg_write <= 0; cfg_index <= '0; cfg_data <= '0;
    cmd_valid <= 0; cmd <= '0; r_index <= '0; phi_index <= '0; z_index <= '0;
    field_value <= '0;
    tx_idle = 1; rx_idle = 1; hold_request = 0; idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset grid, extreme values, boundaries, wrap, bad indexes, unused codes
    send_item(CMD_WR_PHI, 0, 0, 0, 32'h7FFF_FFFF);
    send_item(CMD_WR_Z, 0, 0, 0, 32'h8000_0000);
    send_item(CMD_WR_R, 32, 31, 31, 32'h8000_0000);
    run_compute(CMD_CURL_R, 0, 0, 0);
    run_compute(CMD_CURL_R, 31, 31, 32);
    run_compute(CMD_CURL_PHI, 0, 0, 0);
    run_compute(CMD_CURL_PHI, 32, 31, 32);
    run_compute(CMD_CURL_Z, 0, 0, 0);
    run_compute(CMD_CURL_Z, 32, 31, 31);
    run_compute(CMD_CURL_Z, 31, 0, 7);
    run_compute(CMD_CURL_R, 32, 0, 0);
    run_compute(CMD_CURL_PHI, 0, 0, 33);
    run_compute(CMD_CURL_Z, 0, 0, 32);
    run_compute(CMD_CURL_PHI, 63, 31, 63);
    send_item(CMD_WR_R, 33, 0, 0, 32'h1234_5678);
    send_item(CMD_WR_PHI, 0, 0, 32, 32'h1234_5678);
    send_item(CMD_WR_Z, 0, 0, 33, 32'h1234_5678);
    send_item(3'd6, 63, 31, 63, 32'hFFFF_FFFF);
    send_item(3'd7, 0, 0, 0, 32'h0);

    // Smallest grid, then zero counts acting as one with tiny dr and huge inverses
    configure(1, 1, 1, 65536, 65536, 65536, 65536);
    random_phase(60);
    configure(0, 0, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(60);
    // Oversize counts clamp to the maximum; huge dr, tiny inverses
    configure(63, 63, 63, 32'hFFFF_FFFF, 1, 1, 1);
    random_phase(60);
    // dr of zero: every radius divisor is zero
    configure(5, 7, 3, 0, 65536, 65536, 65536);
    random_phase(60);

    for (int p = 0; p < 5; p++) begin
      configure(6'($urandom_range(1, 8)), 6'($urandom_range(1, 8)), 6'($urandom_range(1, 8)),
                $urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20),
                (p == 2) ? $urandom : $urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20));
      if (p == 1) begin
        // receiver backs off while the sender keeps streaming
        tx_idle = 0;
        hold_request = 1;
      end
      random_phase(90);
    end

    cmd_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.owed.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/cylcurl_pkg.sv
rtl/cylindrical_yee_curl_h_unit.sv
verif/testbench.sv
